// File: src/bis_pkg.sv
// Shared types and constants for the bounded id set.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bis_pkg;

    localparam int DEF_CAPACITY = 16;
    localparam int ID_W         = 32;
    localparam int COUNT_W      = 5;

    localparam logic [ID_W-1:0] NO_ID = {ID_W{1'b1}};

    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_DEL  = 2'd1;
    localparam logic [1:0] OP_FIND = 2'd2;

    typedef struct packed {
        logic [1:0]             operation;
        logic signed [ID_W-1:0] id;
    } t_req;

    typedef struct packed {
        logic               status;
        logic               found;
        logic [COUNT_W-1:0] count;
    } t_rsp;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } t_state;

    // Broadcast to every cell.
    typedef struct packed {
        logic            cmp_en;
        logic            add_en;
        logic            del_en;
        logic [ID_W-1:0] key;
    } t_cmd;

    // Handed from a cell to the next higher one.
    typedef struct packed {
        logic valid;
        logic seen;
    } t_up;

    // Handed from a cell to the next lower one.
    typedef struct packed {
        logic            valid;
        logic [ID_W-1:0] id;
    } t_dn;

endpackage

`default_nettype wire

// File: src/bis_cell.sv
// One slot of the id chain: stored id, valid flag and registered match.
// Depends on bis_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bis_cell (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire bis_pkg::t_cmd i_cmd,
    input  wire bis_pkg::t_up  i_lo,
    input  wire bis_pkg::t_dn  i_hi,
    output bis_pkg::t_up       o_up,
    output bis_pkg::t_dn       o_dn
);

    logic                     r_valid;
    logic                     r_match;
    logic [bis_pkg::ID_W-1:0] r_id;
    logic                     seen;

    // Match here or anywhere below: this slot and all above it shift on delete.
    assign seen = i_lo.seen | r_match;

    assign o_up.valid = r_valid;
    assign o_up.seen  = seen;
    assign o_dn.valid = r_valid;
    assign o_dn.id    = r_id;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            if (i_cmd.cmp_en) begin
                r_match <= r_valid && (r_id == i_cmd.key);
            end
            // Append into the first free slot: free here, occupied below.
            if (i_cmd.add_en && !r_valid && i_lo.valid) begin
                r_valid <= 1'b1;
            end else if (i_cmd.del_en && seen) begin
                r_valid <= i_hi.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.add_en && !r_valid && i_lo.valid) begin
            r_id <= i_cmd.key;
        end else if (i_cmd.del_en && seen) begin
            r_id <= i_hi.id;
        end
    end

endmodule

`default_nettype wire

// File: src/bounded_id_set_core.sv
// Bounded id set: a chain of CAPACITY slot cells kept in insertion order.
// Flow: a request is taken only while idle and is not overlapped with the next
//   one (accept, compare in every cell, then resolve the match chain and shift);
//   the result beat is registered on the shift, held back while the output stalls.
// Reset: all slot valid flags clear at once; the set is empty and ready
//   in the first cycle after reset, with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module bounded_id_set_core #(
    parameter int CAPACITY = bis_pkg::DEF_CAPACITY
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // request channel
    input  wire logic          i_in_valid,
    input  wire bis_pkg::t_req i_in_data,
    output logic               o_in_stall,
    // result channel
    output logic               o_out_valid,
    output bis_pkg::t_rsp      o_out_data,
    input  wire logic          i_out_stall
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    bis_pkg::t_state r_state, n_state;
    bis_pkg::t_req   r_req, n_req;
    logic [CNT_W-1:0] r_count, n_count;
    logic            r_out_valid, n_out_valid;
    bis_pkg::t_rsp   r_out, n_out;

    bis_pkg::t_cmd   cmd;
    bis_pkg::t_up    up [0:CAPACITY];
    bis_pkg::t_dn    dn [0:CAPACITY];

    logic full, empty, found, no_id, out_free, upd_go;
    logic add_ok, del_ok;

    // Chain ends: below slot 0 counts as occupied so an add lands there
    // when the set is empty; above the last slot nothing shifts in.
    assign up[0].valid       = 1'b1;
    assign up[0].seen        = 1'b0;
    assign dn[CAPACITY].valid = 1'b0;
    assign dn[CAPACITY].id    = bis_pkg::NO_ID;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        bis_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cmd),
            .i_lo    (up[g]),
            .i_hi    (dn[g+1]),
            .o_up    (up[g+1]),
            .o_dn    (dn[g])
        );
    end

    // Slots fill from the bottom, so the end cells tell full and empty.
    assign full     = up[CAPACITY].valid;
    assign empty    = !up[1].valid;
    assign found    = up[CAPACITY].seen;
    assign no_id    = (r_req.id == bis_pkg::NO_ID);
    assign out_free = !r_out_valid || !i_out_stall;
    assign upd_go   = (r_state == bis_pkg::ST_UPD) && out_free;

    assign add_ok = (r_req.operation == bis_pkg::OP_ADD) && !no_id && !full && !found;
    assign del_ok = (r_req.operation == bis_pkg::OP_DEL) && !no_id && !empty && found;

    assign cmd.cmp_en = (r_state == bis_pkg::ST_CMP);
    assign cmd.add_en = upd_go && add_ok;
    assign cmd.del_en = upd_go && del_ok;
    assign cmd.key    = r_req.id;

    assign o_in_stall  = (r_state != bis_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_count     = r_count;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        // Drop the result beat once taken.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            bis_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_in_data;
                    n_state = bis_pkg::ST_CMP;
                end
            end
            bis_pkg::ST_CMP: begin
                n_state = bis_pkg::ST_UPD;
            end
            bis_pkg::ST_UPD: begin
                // Hold here until the output register can take the beat.
                if (out_free) begin
                    if (add_ok) begin
                        n_count = r_count + CNT_W'(1);
                    end else if (del_ok) begin
                        n_count = r_count - CNT_W'(1);
                    end
                    n_out.found  = 1'b0;
                    n_out.status = 1'b1;
                    priority if (r_req.operation == bis_pkg::OP_ADD) begin
                        n_out.status = !add_ok;
                    end else if (r_req.operation == bis_pkg::OP_DEL) begin
                        n_out.status = !del_ok;
                    end else if (r_req.operation == bis_pkg::OP_FIND) begin
                        n_out.status = 1'b0;
                        n_out.found  = found && !no_id;
                    end else begin
                        n_out.status = 1'b1;
                    end
                    n_out.count = bis_pkg::COUNT_W'(n_count);
                    n_out_valid = 1'b1;
                    n_state     = bis_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bis_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bis_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_out <= n_out;
    end

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// Self-checking bench for bounded_id_set_core: a directed table, then random
// add/delete/find traffic checked against an in-bench model of the id set.
// Depends on bis_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_top;
    import bis_pkg::*;

    localparam int          SET_CAP      = DEF_CAPACITY;
    localparam logic [1:0]  OP_UNUSED    = 2'd3;
    localparam int          RANDOM_BEATS = 750;
    localparam int          POOL_SIZE    = 24;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          DRAIN_CYCLES = 12;
    localparam int          CYCLE_LIMIT  = 200000;

    typedef struct {
        t_req req;
        bit   typed;
        t_rsp rsp;
    } t_dir_row;

    // Every block input starts at a known value.
    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    t_req in_data   = '0;
    logic out_stall = 1'b0;
    logic in_stall;
    logic out_valid;
    t_rsp out_data;

    // Typed expectation that rides along with the beat on offer.
    bit   beat_typed     = 1'b0;
    t_rsp beat_typed_rsp = '0;

    // Model of the set: slots in insertion order plus the stored count.
    logic [ID_W-1:0] set_slots [SET_CAP];
    int              set_count;

    t_rsp            rsp_expected [$];
    t_dir_row        dir_rows [$];
    logic [ID_W-1:0] id_pool [POOL_SIZE];
    int              fail_cnt  = 0;
    int              cycle_cnt = 0;
    int              burst_left = 0;

    bounded_id_set_core #(
        .CAPACITY (SET_CAP)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Apply one request to the set model and return the result it must give.
    function automatic t_rsp apply_request(input t_req req);
        t_rsp rsp;
        int   pos;
        pos = -1;
        for (int i = 0; i < set_count; i++) begin
            if (pos < 0 && set_slots[i] == req.id) begin
                pos = i;
            end
        end
        rsp = '0;
        rsp.status = 1'b1;
        case (req.operation)
            OP_ADD: begin
                if (req.id != NO_ID && set_count < SET_CAP && pos < 0) begin
                    set_slots[set_count] = req.id;
                    set_count++;
                    rsp.status = 1'b0;
                end
            end
            OP_DEL: begin
                if (req.id != NO_ID && pos >= 0) begin
                    // Close the gap: later entries move down one place.
                    for (int i = pos; i + 1 < set_count; i++) begin
                        set_slots[i] = set_slots[i + 1];
                    end
                    set_count--;
                    set_slots[set_count] = NO_ID;
                    rsp.status = 1'b0;
                end
            end
            OP_FIND: begin
                rsp.status = 1'b0;
                rsp.found  = (req.id != NO_ID && pos >= 0);
            end
            default: begin
                // Unused code: no change, error answer.
            end
        endcase
        rsp.count = set_count[COUNT_W-1:0];
        return rsp;
    endfunction

    function automatic void put_row(input logic [1:0] op, input logic [ID_W-1:0] id,
                                    input bit typed = 1'b0, input t_rsp rsp = '0);
        t_dir_row row;
        row.req.operation = op;
        row.req.id        = id;
        row.typed         = typed;
        row.rsp           = rsp;
        dir_rows.push_back(row);
    endfunction

    // Mostly ids from a small pool so adds collide and deletes hit; some noise.
    function automatic logic [ID_W-1:0] pick_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            return id_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else if (r < 93) begin
            return $urandom;
        end
        return NO_ID;
    endfunction

    // Offer one beat, hold it until accepted, then pace the sender in bursts.
    task automatic offer_beat(input t_req req, input bit typed, input t_rsp rsp);
        int gap;
        in_valid       <= 1'b1;
        in_data        <= req;
        beat_typed     <= typed;
        beat_typed_rsp <= rsp;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            // End of burst: drop valid for a random gap, or run straight on.
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(0, 24);
        end
    endtask

    // Check the result beat first, then record the expectation of a new
    // request beat, so that a stray result is never matched to a fresh one.
    always @(posedge clk) begin
        t_rsp want;
        if (rst_n && out_valid && !out_stall) begin
            if (rsp_expected.size() == 0) begin
                $error("unexpected result beat status=%0b found=%0b count=%0d",
                       out_data.status, out_data.found, out_data.count);
                fail_cnt++;
            end else begin
                want = rsp_expected.pop_front();
                if (out_data.status !== want.status) begin
                    $error("field status mismatch, expected %0b, actual %0b",
                           want.status, out_data.status);
                    fail_cnt++;
                end
                if (out_data.found !== want.found) begin
                    $error("field found mismatch, expected %0b, actual %0b",
                           want.found, out_data.found);
                    fail_cnt++;
                end
                if (out_data.count !== want.count) begin
                    $error("field count mismatch, expected %0d, actual %0d",
                           want.count, out_data.count);
                    fail_cnt++;
                end
            end
        end
        if (rst_n && in_valid && !in_stall) begin
            // Advance the model on every beat; typed rows override its answer.
            want = apply_request(in_data);
            if (beat_typed) begin
                want = beat_typed_rsp;
            end
            rsp_expected.push_back(want);
        end
    end

    // Receiver: stretches of free flow, random stalls and solid stalls, with
    // two long hold-offs so the block backs up and stalls its request side.
    initial begin
        int seg;
        int len;
        int mode;
        int pct;
        seg = 0;
        @(posedge clk);
        while (!rst_n) begin
            @(posedge clk);
        end
        forever begin
            seg++;
            if (seg == 60 || seg == 150) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            mode = $urandom_range(0, 9);
            len  = $urandom_range(1, 40);
            pct  = (mode < 3) ? 0 : (mode < 8) ? $urandom_range(10, 70) : 100;
            repeat (len) begin
                out_stall <= ($urandom_range(1, 100) <= pct);
                @(posedge clk);
            end
        end
    end

    // Watchdog: a run that never drains ends here.
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        t_req req;
        int   add_pct;
        int   r;

        for (int i = 0; i < SET_CAP; i++) begin
            set_slots[i] = NO_ID;
        end
        set_count = 0;

        // Pool: extremes plus random ids, more than the set can hold.
        id_pool[0] = 32'h0000_0000;
        id_pool[1] = 32'h7FFF_FFFF;
        id_pool[2] = 32'h8000_0000;
        id_pool[3] = 32'hFFFF_FFFE;
        for (int i = 4; i < POOL_SIZE; i++) begin
            id_pool[i] = $urandom;
            if (id_pool[i] == NO_ID) begin
                id_pool[i] = 32'h0000_0001;
            end
        end

        // Directed table. Empty set first: find miss, delete on empty,
        // add of no-id, unused code.
        put_row(OP_FIND,   32'd0,        1'b1, '{1'b0, 1'b0, 5'd0});
        put_row(OP_DEL,    32'd5,        1'b1, '{1'b1, 1'b0, 5'd0});
        put_row(OP_ADD,    NO_ID,        1'b1, '{1'b1, 1'b0, 5'd0});
        put_row(OP_UNUSED, 32'd0,        1'b1, '{1'b1, 1'b0, 5'd0});
        // Extreme ids, then a duplicate add.
        put_row(OP_ADD,    32'h8000_0000, 1'b1, '{1'b0, 1'b0, 5'd1});
        put_row(OP_ADD,    32'h7FFF_FFFF, 1'b1, '{1'b0, 1'b0, 5'd2});
        put_row(OP_ADD,    32'd0,        1'b1, '{1'b0, 1'b0, 5'd3});
        put_row(OP_ADD,    32'd0,        1'b1, '{1'b1, 1'b0, 5'd3});
        put_row(OP_FIND,   32'h8000_0000, 1'b1, '{1'b0, 1'b1, 5'd3});
        // No-id never matches, not even among free slots.
        put_row(OP_FIND,   NO_ID,        1'b1, '{1'b0, 1'b0, 5'd3});
        put_row(OP_DEL,    NO_ID,        1'b1, '{1'b1, 1'b0, 5'd3});
        put_row(OP_DEL,    32'd1234,     1'b1, '{1'b1, 1'b0, 5'd3});
        // Fill to capacity, then an add on a full set.
        for (int k = 0; k < SET_CAP - 3; k++) begin
            put_row(OP_ADD, 32'h0001_0000 + k * 32'h1111);
        end
        put_row(OP_ADD,    32'd42,       1'b1, '{1'b1, 1'b0, 5'd16});
        // Delete the oldest entry: every later slot shifts down.
        put_row(OP_DEL,    32'h8000_0000, 1'b1, '{1'b0, 1'b0, 5'd15});
        put_row(OP_FIND,   32'h7FFF_FFFF);
        put_row(OP_UNUSED, NO_ID,        1'b1, '{1'b1, 1'b0, 5'd15});

        // Hold reset low, then release it once.
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            offer_beat(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);
        end

        // Random traffic in phases that lean toward filling or emptying.
        add_pct = 40;
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 60 == 0) begin
                add_pct = $urandom_range(15, 65);
            end
            r = $urandom_range(0, 99);
            if (r < 3) begin
                req.operation = OP_UNUSED;
            end else if (r < 3 + add_pct) begin
                req.operation = OP_ADD;
            end else if (r < 83) begin
                req.operation = OP_DEL;
            end else begin
                req.operation = OP_FIND;
            end
            req.id = pick_id();
            offer_beat(req, 1'b0, '0);
        end
        in_valid <= 1'b0;

        // Drain every expected result, then idle a little for strays.
        while (rsp_expected.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
